>>> design/phss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package phss_pkg;

  localparam int GUN_COUNT   = 4;
  localparam int MAX_RESULTS = 4;
  localparam int GUN_W       = (GUN_COUNT > 1) ? $clog2(GUN_COUNT) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int ACT_W      = 3;
  localparam int GUNF_W     = 3;
  localparam int HOLD_MS_W  = 16;
  localparam int THR_W      = 12;
  localparam int US_W       = 23;
  localparam int PROD_W     = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [US_W-1:0]   HOLD_MIN_US = 23'd50;
  localparam logic [US_W-1:0]   HOLD_MAX_US = 23'd5000000;
  localparam logic [PROD_W-1:0] US_PER_MS   = 26'd1000;

  localparam logic [ACT_W-1:0] ACT_FIRE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PEAK_EDGE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TICK      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ABORT     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ABORT_ALL = 3'd4;
  localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PICK_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_HOLD  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PEAK = 2'd1,
    PH_HOLD = 2'd2
  } phase_t;

  typedef struct packed {
    logic load;
    logic single;
    logic step;
  } phss_cmd_t;

  typedef struct packed {
    logic in_scan;
    logic in_undef;
    logic emit;
    logic scan_end;
    logic slot_free;
  } phss_status_t;

endpackage
`default_nettype wire

>>> design/phss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module phss_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire phss_pkg::phss_status_t sts,
  output phss_pkg::phss_cmd_t        cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_SCAN
  } state_t;

  state_t state;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid && !in_stall;
    cmd.single = (state == S_SINGLE) && sts.slot_free;
    cmd.step   = (state == S_SCAN) && (!sts.emit || sts.slot_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load && !sts.in_undef) begin
            state    <= sts.in_scan ? S_SCAN : S_SINGLE;
            in_stall <= 1'b1;
          end
        end
        S_SINGLE: begin
          if (cmd.single) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cmd.step && sts.scan_end) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/phss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module phss_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire phss_pkg::phss_cmd_t                 cmd,
  output phss_pkg::phss_status_t                   sts,
  input  wire logic [phss_pkg::ACT_W-1:0]          action,
  input  wire logic [phss_pkg::GUNF_W-1:0]         gun,
  input  wire logic [phss_pkg::HOLD_MS_W-1:0]      hold_ms,
  input  wire logic                                armed,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [phss_pkg::GUNF_W-1:0]              gun_out,
  output logic                                     accepted,
  output logic [1:0]                               phase,
  output logic                                     threshold_write,
  output logic [phss_pkg::THR_W-1:0]               threshold_mv,
  output logic                                     in1_drive,
  output logic                                     cmp_route,
  output logic                                     peak_edge_enable,
  output logic                                     last,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [phss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [phss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic [phss_pkg::THR_W-1:0] pick_thr;
  logic [phss_pkg::THR_W-1:0] hold_thr;
  logic [phss_pkg::THR_W-1:0] near_zero_thr;
  logic [phss_pkg::US_W-1:0]  def_hold;

  // per-gun state
  phss_pkg::phase_t          gun_phase [phss_pkg::GUN_COUNT];
  logic [phss_pkg::US_W-1:0] hold_rem  [phss_pkg::GUN_COUNT];
  logic                      mux_st    [phss_pkg::GUN_COUNT];

  // latched input word and scan state
  logic [phss_pkg::ACT_W-1:0]     act_q;
  logic [phss_pkg::GUNF_W-1:0]    gun_q;
  logic [phss_pkg::HOLD_MS_W-1:0] hold_ms_q;
  logic                           armed_q;
  logic [phss_pkg::GUN_COUNT-1:0] hit_mask;
  logic [phss_pkg::GUN_W-1:0]     scan_idx;
  logic [phss_pkg::CNT_W-1:0]     res_cnt;

  logic [phss_pkg::GUN_COUNT-1:0] hit_mask_next;
  logic                           in_tick;
  logic                           in_abort_all;

  assign cfg_ready    = 1'b1;
  assign in_tick      = (action == phss_pkg::ACT_TICK);
  assign in_abort_all = (action == phss_pkg::ACT_ABORT_ALL);

  always_comb begin
    for (int i = 0; i < phss_pkg::GUN_COUNT; i++) begin
      hit_mask_next[i] =
        (in_tick && (gun_phase[i] == phss_pkg::PH_HOLD) &&
         (hold_rem[i] <= phss_pkg::US_W'(1))) ||
        (in_abort_all && (gun_phase[i] != phss_pkg::PH_IDLE));
    end
  end

  // scan step status
  logic scan_hit;
  logic scan_rest;
  logic scan_last;

  always_comb begin
    scan_hit  = hit_mask[scan_idx];
    scan_rest = 1'b0;
    for (int j = 0; j < phss_pkg::GUN_COUNT; j++) begin
      if (phss_pkg::GUN_W'(j) > scan_idx && hit_mask[j]) begin
        scan_rest = 1'b1;
      end
    end
    scan_last = !scan_rest || (res_cnt == phss_pkg::CNT_W'(phss_pkg::MAX_RESULTS - 1));
  end

  always_comb begin
    sts           = '0;
    sts.in_scan   = in_tick || in_abort_all;
    sts.in_undef  = (action > phss_pkg::ACT_QUERY);
    sts.emit      = scan_hit && (res_cnt < phss_pkg::CNT_W'(phss_pkg::MAX_RESULTS));
    sts.scan_end  = (scan_idx == phss_pkg::GUN_W'(phss_pkg::GUN_COUNT - 1));
    sts.slot_free = !out_valid || !out_stall;
  end

  // single-gun action
  logic                       g_ok;
  logic [phss_pkg::GUN_W-1:0] gi;
  logic [phss_pkg::PROD_W-1:0] prod_us;
  logic [phss_pkg::PROD_W-1:0] req_us;
  logic [phss_pkg::US_W-1:0]  clamp_us;
  phss_pkg::phase_t           cur_ph;
  phss_pkg::phase_t           new_ph;
  logic                       new_mux;
  logic                       sg_acc;
  logic                       sg_tw;
  logic [phss_pkg::THR_W-1:0] sg_thr;
  logic                       wr_rem;
  logic [phss_pkg::US_W-1:0]  rem_val;

  assign g_ok = ({1'b0, gun_q} < (phss_pkg::GUNF_W + 1)'(phss_pkg::GUN_COUNT));
  assign gi   = phss_pkg::GUN_W'(gun_q);

  always_comb begin
    prod_us = phss_pkg::PROD_W'(hold_ms_q) * phss_pkg::US_PER_MS;
    req_us  = (hold_ms_q == '0) ? phss_pkg::PROD_W'(def_hold) : prod_us;
    if (req_us < phss_pkg::PROD_W'(phss_pkg::HOLD_MIN_US)) begin
      clamp_us = phss_pkg::HOLD_MIN_US;
    end else if (req_us > phss_pkg::PROD_W'(phss_pkg::HOLD_MAX_US)) begin
      clamp_us = phss_pkg::HOLD_MAX_US;
    end else begin
      clamp_us = phss_pkg::US_W'(req_us);
    end
  end

  always_comb begin
    cur_ph  = g_ok ? gun_phase[gi] : phss_pkg::PH_IDLE;
    new_ph  = cur_ph;
    new_mux = g_ok ? mux_st[gi] : 1'b0;
    sg_acc  = 1'b0;
    sg_tw   = 1'b0;
    sg_thr  = '0;
    wr_rem  = 1'b0;
    rem_val = '0;
    if (g_ok) begin
      case (act_q)
        phss_pkg::ACT_FIRE: begin
          if (armed_q && cur_ph == phss_pkg::PH_IDLE) begin
            new_ph  = phss_pkg::PH_PEAK;
            new_mux = 1'b1;
            sg_acc  = 1'b1;
            sg_tw   = 1'b1;
            sg_thr  = pick_thr;
            wr_rem  = 1'b1;
            rem_val = clamp_us;
          end
        end
        phss_pkg::ACT_PEAK_EDGE: begin
          if (cur_ph == phss_pkg::PH_PEAK) begin
            new_ph = phss_pkg::PH_HOLD;
            sg_acc = 1'b1;
            sg_tw  = 1'b1;
            sg_thr = hold_thr;
          end
        end
        phss_pkg::ACT_ABORT: begin
          if (cur_ph != phss_pkg::PH_IDLE) begin
            new_ph = phss_pkg::PH_IDLE;
            sg_acc = 1'b1;
            sg_tw  = 1'b1;
            sg_thr = near_zero_thr;
            wr_rem = 1'b1;
          end
        end
        phss_pkg::ACT_QUERY: begin
          sg_acc = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_thr      <= 12'd2000;
      hold_thr      <= 12'd800;
      near_zero_thr <= 12'd100;
      def_hold      <= 23'd50;
      for (int i = 0; i < phss_pkg::GUN_COUNT; i++) begin
        gun_phase[i] <= phss_pkg::PH_IDLE;
        hold_rem[i]  <= '0;
        mux_st[i]    <= 1'b0;
      end
      out_valid <= 1'b0;
      scan_idx  <= '0;
      res_cnt   <= '0;
      hit_mask  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          phss_pkg::REG_PICK_THR:  pick_thr      <= phss_pkg::THR_W'(cfg_data);
          phss_pkg::REG_HOLD_THR:  hold_thr      <= phss_pkg::THR_W'(cfg_data);
          phss_pkg::REG_NEAR_ZERO: near_zero_thr <= phss_pkg::THR_W'(cfg_data);
          phss_pkg::REG_DEF_HOLD:  def_hold      <= cfg_data;
          default: begin
          end
        endcase
      end

      if (cmd.single || (cmd.step && sts.emit)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cmd.load) begin
        act_q     <= action;
        gun_q     <= gun;
        hold_ms_q <= hold_ms;
        armed_q   <= armed;
        hit_mask  <= hit_mask_next;
        scan_idx  <= '0;
        res_cnt   <= '0;
      end

      if (cmd.single) begin
        gun_out          <= gun_q;
        accepted         <= sg_acc;
        phase            <= new_ph;
        threshold_write  <= sg_tw;
        threshold_mv     <= sg_thr;
        in1_drive        <= g_ok && (new_ph != phss_pkg::PH_IDLE);
        cmp_route        <= new_mux;
        peak_edge_enable <= g_ok && (new_ph == phss_pkg::PH_PEAK);
        last             <= 1'b1;
        if (g_ok) begin
          gun_phase[gi] <= new_ph;
          mux_st[gi]    <= new_mux;
          if (wr_rem) begin
            hold_rem[gi] <= rem_val;
          end
        end
      end

      if (cmd.step) begin
        scan_idx <= scan_idx + 1'b1;
        if (scan_hit) begin
          // expiry or abort-all: decay the gun
          gun_phase[scan_idx] <= phss_pkg::PH_IDLE;
          hold_rem[scan_idx]  <= '0;
        end else if (act_q == phss_pkg::ACT_TICK &&
                     gun_phase[scan_idx] == phss_pkg::PH_HOLD) begin
          hold_rem[scan_idx] <= hold_rem[scan_idx] - 1'b1;
        end
        if (sts.emit) begin
          res_cnt          <= res_cnt + 1'b1;
          gun_out          <= phss_pkg::GUNF_W'(scan_idx);
          accepted         <= 1'b1;
          phase            <= phss_pkg::PH_IDLE;
          threshold_write  <= 1'b1;
          threshold_mv     <= near_zero_thr;
          in1_drive        <= 1'b0;
          cmp_route        <= mux_st[scan_idx];
          peak_edge_enable <= 1'b0;
          last             <= scan_last;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/peak_hold_solenoid_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Peak-and-hold sequencer for four solenoid guns. Fire, peak edge, abort and
// query are each accepted, then give one result word; microsecond tick and
// abort-all walk the guns one per cycle through a shared countdown decrement
// (held while a due word meets a stalled one) and give one word per gun that
// expires or is aborted. Actions 6 and 7 are taken with no word. Hold times
// are clamped to 50 us .. 5 s; thresholds are passed through in mV.
module peak_hold_solenoid_sequencer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [phss_pkg::ACT_W-1:0]      action,
  input  wire logic [phss_pkg::GUNF_W-1:0]     gun,
  input  wire logic [phss_pkg::HOLD_MS_W-1:0]  hold_ms,
  input  wire logic                            armed,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [phss_pkg::GUNF_W-1:0]          gun_out,
  output logic                                 accepted,
  output logic [1:0]                           phase,
  output logic                                 threshold_write,
  output logic [phss_pkg::THR_W-1:0]           threshold_mv,
  output logic                                 in1_drive,
  output logic                                 cmp_route,
  output logic                                 peak_edge_enable,
  output logic                                 last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [phss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [phss_pkg::CFG_DATA_W-1:0] cfg_data
);

  phss_pkg::phss_cmd_t    cmd;
  phss_pkg::phss_status_t sts;

  phss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  phss_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .action           (action),
    .gun              (gun),
    .hold_ms          (hold_ms),
    .armed            (armed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .gun_out          (gun_out),
    .accepted         (accepted),
    .phase            (phase),
    .threshold_write  (threshold_write),
    .threshold_mv     (threshold_mv),
    .in1_drive        (in1_drive),
    .cmp_route        (cmp_route),
    .peak_edge_enable (peak_edge_enable),
    .last             (last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule
`default_nettype wire

>>> design/phss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module phss_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [phss_pkg::GUNF_W-1:0]   gun_out,
  input wire logic                          accepted,
  input wire logic [1:0]                    phase,
  input wire logic                          threshold_write,
  input wire logic [phss_pkg::THR_W-1:0]    threshold_mv,
  input wire logic                          in1_drive,
  input wire logic                          cmp_route,
  input wire logic                          peak_edge_enable,
  input wire logic                          last
);

  // stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gun_out) && $stable(last))
    else $error("stalled result word changed");

  a_thr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !threshold_write |-> threshold_mv == '0)
    else $error("threshold value without threshold write");

  a_tw_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && threshold_write |-> accepted)
    else $error("threshold write on a word that took no effect");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == 2'(phss_pkg::PH_PEAK) |->
      in1_drive && peak_edge_enable && cmp_route)
    else $error("peak phase without drive, mux and edge enable");

  a_not_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase != 2'(phss_pkg::PH_PEAK) |->
      !peak_edge_enable && (in1_drive == (phase == 2'(phss_pkg::PH_HOLD))))
    else $error("drive or edge enable disagrees with phase");

endmodule

bind peak_hold_solenoid_sequencer_top phss_checker u_phss_checker (.*);
`default_nettype wire
